// ===== rtl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// AES package
// Byte tables and GF(2^8) column functions shared by the cipher modules.
// ----------------------------------------------------------------------------
package aes_pkg;

  typedef struct packed {
    logic decrypt;
    logic first;
    logic last;
  } round_ctl_t;

  localparam logic [2:0] REG_KEY0     = 3'd0;
  localparam logic [2:0] REG_KEY1     = 3'd1;
  localparam logic [2:0] REG_KEY2     = 3'd2;
  localparam logic [2:0] REG_KEY3     = 3'd3;
  localparam logic [2:0] REG_LONG_KEY = 3'd4;
  localparam logic [2:0] REG_DECRYPT  = 3'd5;

  localparam logic [7:0] GF_POLY = 8'h1b;

  localparam logic [2047:0] SBOX_FLAT = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  localparam logic [2047:0] INV_SBOX_FLAT = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] sub_byte(input logic [7:0] b);
    sub_byte = SBOX_FLAT[{~b, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] inv_sub_byte(input logic [7:0] b);
    inv_sub_byte = INV_SBOX_FLAT[{~b, 3'b000} +: 8];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {sub_byte(w[31:24]), sub_byte(w[23:16]), sub_byte(w[15:8]), sub_byte(w[7:0])};
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[31:24];
    a1 = c[23:16];
    a2 = c[15:8];
    a3 = c[7:0];
    mix_col = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
               a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
               a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
               xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] a [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    logic [7:0] x2, x4, x8;
    for (int i = 0; i < 4; i++) begin
      a[i] = c[31-8*i -: 8];
      x2 = xtime(a[i]);
      x4 = xtime(x2);
      x8 = xtime(x4);
      m9[i] = x8 ^ a[i];
      m11[i] = x8 ^ x2 ^ a[i];
      m13[i] = x8 ^ x4 ^ a[i];
      m14[i] = x8 ^ x4 ^ x2;
    end
    inv_mix_col = {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
                   m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
                   m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
                   m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    for (int c = 0; c < 4; c++) mix_cols[127-32*c -: 32] = mix_col(s[127-32*c -: 32]);
  endfunction

  function automatic logic [127:0] inv_mix_cols(input logic [127:0] s);
    for (int c = 0; c < 4; c++) inv_mix_cols[127-32*c -: 32] = inv_mix_col(s[127-32*c -: 32]);
  endfunction

endpackage

// ===== rtl/aes_round.sv =====
// ----------------------------------------------------------------------------
// AES round
// One cipher or equivalent inverse cipher round, or the initial key addition.
// ----------------------------------------------------------------------------
module aes_round import aes_pkg::*; (
  input  logic [127:0] state_in,
  input  logic [127:0] round_key,
  input  round_ctl_t   ctl,
  output logic [127:0] state_out
);

  logic [127:0] enc_sh, dec_sh, enc_mx, dec_mx, key_use;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int row = 0; row < 4; row++) begin
        enc_sh[127-8*(row+4*c) -: 8] =
          sub_byte(state_in[127-8*(row+4*((c+row)%4)) -: 8]);
        dec_sh[127-8*(row+4*c) -: 8] =
          inv_sub_byte(state_in[127-8*(row+4*((c+4-row)%4)) -: 8]);
      end
    end
    enc_mx = ctl.last ? enc_sh : mix_cols(enc_sh);
    dec_mx = ctl.last ? dec_sh : inv_mix_cols(dec_sh);
    key_use = (!ctl.first && !ctl.last) ? inv_mix_cols(round_key) : round_key;
    if (ctl.first) begin
      state_out = state_in ^ round_key;
    end else if (ctl.decrypt) begin
      state_out = dec_mx ^ key_use;
    end else begin
      state_out = enc_mx ^ round_key;
    end
  end

endmodule

// ===== rtl/aes_block_cipher.sv =====
// ----------------------------------------------------------------------------
// AES block cipher
// AES-128/256 ECB encryption and decryption of one 128-bit word per start.
// ----------------------------------------------------------------------------
// A word passes a key-read state, then the initial key addition and each round,
// each fed by a round key read from the key memory. After reset or a write to
// a defined register (index 0 to 5), the next start first expands the key
// schedule into that memory, one round key per cycle. The result is shown for
// exactly one cycle with out_valid and must be taken then; busy falls in that
// same cycle, so a new start can follow.
module aes_block_cipher import aes_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  output logic        out_valid,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXPAND = 2'd1;
  localparam logic [1:0] ST_PRE    = 2'd2;
  localparam logic [1:0] ST_RUN    = 2'd3;

  logic [63:0]  key_r [4];
  logic         long_r, dec_r, stale_r;
  logic [1:0]   state_r;
  logic [3:0]   kcnt_r, rnd_r;
  logic [31:0]  win_r [8];
  logic [7:0]   rcon_r;
  logic [127:0] blk_r, blk_nxt;
  logic [63:0]  rk_hi_r, rk_lo_r;
  logic         out_valid_r;
  logic [63:0]  mem_hi [15];
  logic [63:0]  mem_lo [15];

  logic [3:0]   nr, rd_idx, rd_addr;
  logic         rd_en;
  logic         direct, rot;
  logic [31:0]  base [4];
  logic [31:0]  nw [4];
  logic [31:0]  tw;
  logic [127:0] wdata;
  round_ctl_t   ctl;

  assign nr = long_r ? 4'd14 : 4'd10;
  assign busy = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_result_high = blk_r[127:64];
  assign out_result_low = blk_r[63:0];

  always_comb begin
    direct = long_r ? (kcnt_r < 4'd2) : (kcnt_r == 4'd0);
    rot = !long_r || !kcnt_r[0];
    for (int i = 0; i < 4; i++) base[i] = long_r ? win_r[i] : win_r[i+4];
    tw = rot ? (sub_word({win_r[7][23:0], win_r[7][31:24]}) ^ {rcon_r, 24'h000000})
             : sub_word(win_r[7]);
    nw[0] = base[0] ^ tw;
    for (int i = 1; i < 4; i++) nw[i] = base[i] ^ nw[i-1];
    if (!direct) begin
      wdata = {nw[0], nw[1], nw[2], nw[3]};
    end else if (long_r && kcnt_r == 4'd0) begin
      wdata = {win_r[0], win_r[1], win_r[2], win_r[3]};
    end else begin
      wdata = {win_r[4], win_r[5], win_r[6], win_r[7]};
    end
  end

  always_comb begin
    rd_en = (state_r == ST_PRE) || (state_r == ST_RUN && rnd_r != nr);
    rd_idx = (state_r == ST_PRE) ? 4'd0 : rnd_r + 4'd1;
    rd_addr = dec_r ? nr - rd_idx : rd_idx;
  end

  assign ctl = '{decrypt: dec_r, first: (rnd_r == 4'd0), last: (rnd_r == nr)};

  aes_round u_round (
    .state_in  (blk_r),
    .round_key ({rk_hi_r, rk_lo_r}),
    .ctl       (ctl),
    .state_out (blk_nxt)
  );

  always_ff @(posedge clk) begin
    if (state_r == ST_EXPAND) begin
      mem_hi[kcnt_r] <= wdata[127:64];
      mem_lo[kcnt_r] <= wdata[63:0];
    end
    if (rd_en) begin
      rk_hi_r <= mem_hi[rd_addr];
      rk_lo_r <= mem_lo[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      blk_r <= {in_block_high, in_block_low};
      rcon_r <= 8'h01;
      for (int i = 0; i < 4; i++) begin
        win_r[2*i]   <= key_r[i][63:32];
        win_r[2*i+1] <= key_r[i][31:0];
      end
      if (!long_r) begin
        for (int i = 0; i < 2; i++) begin
          win_r[4+2*i] <= key_r[i][63:32];
          win_r[5+2*i] <= key_r[i][31:0];
        end
      end
    end else if (state_r == ST_EXPAND && !direct) begin
      for (int i = 0; i < 4; i++) begin
        win_r[i]   <= win_r[i+4];
        win_r[i+4] <= nw[i];
      end
      if (rot) rcon_r <= xtime(rcon_r);
    end else if (state_r == ST_RUN) begin
      blk_r <= blk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      long_r <= 1'b0;
      dec_r <= 1'b0;
      stale_r <= 1'b1;
      state_r <= ST_IDLE;
      kcnt_r <= '0;
      rnd_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            kcnt_r <= '0;
            state_r <= stale_r ? ST_EXPAND : ST_PRE;
          end
        end
        ST_EXPAND: begin
          kcnt_r <= kcnt_r + 4'd1;
          if (kcnt_r == nr) begin
            stale_r <= 1'b0;
            state_r <= ST_PRE;
          end
        end
        ST_PRE: begin
          rnd_r <= '0;
          state_r <= ST_RUN;
        end
        ST_RUN: begin
          rnd_r <= rnd_r + 4'd1;
          if (rnd_r == nr) begin
            out_valid_r <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY0:     key_r[0] <= cfg_data;
          REG_KEY1:     key_r[1] <= cfg_data;
          REG_KEY2:     key_r[2] <= cfg_data;
          REG_KEY3:     key_r[3] <= cfg_data;
          REG_LONG_KEY: long_r <= cfg_data[0];
          REG_DECRYPT:  dec_r <= cfg_data[0];
          default: ;
        endcase
        if (cfg_index <= REG_DECRYPT) stale_r <= 1'b1;
      end
    end
  end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// AES block cipher testbench
// Sends 128-bit words through aes_block_cipher under changing keys, key
// lengths and directions. A behavioral AES model predicts each result, which
// is checked field by field when out_valid is seen.
// ----------------------------------------------------------------------------
module tb;
  import aes_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_UNUSED6 = 3'd6;
  localparam logic [2:0] REG_UNUSED7 = 3'd7;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [63:0] high;
    logic [63:0] low;
  } cipher_word_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [63:0] in_block_high;
  logic [63:0] in_block_low;
  logic out_valid;
  logic [63:0] out_result_high;
  logic [63:0] out_result_low;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [63:0] cfg_data;

  logic [63:0] key_reg [4];
  logic long_key_reg;
  logic decrypt_reg;
  logic [7:0] sbox_tbl [256];
  logic [7:0] inv_sbox_tbl [256];
  logic [127:0] sched [15];
  cipher_word_t pending_words [$];
  bit idle_en;
  int fail_count;
  int stall_cycles;

  aes_block_cipher DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_block_high(in_block_high), .in_block_low(in_block_low),
    .out_valid(out_valid), .out_result_high(out_result_high),
    .out_result_low(out_result_low),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ a;
      a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
    end
    return p;
  endfunction

  function automatic void build_sbox();
    logic [7:0] s, r, b;
    for (int x = 0; x < 256; x++) begin
      s = x[7:0];
      r = 8'h01;
      for (int i = 0; i < 7; i++) begin
        s = gf_mul(s, s);
        r = gf_mul(r, s);
      end
      b = r;
      sbox_tbl[x] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                    ^ {b[3:0], b[7:4]} ^ 8'h63;
      inv_sbox_tbl[sbox_tbl[x]] = x[7:0];
    end
  endfunction

  function automatic logic [31:0] column_mix(input logic [31:0] c, input logic [7:0] m0,
                                             input logic [7:0] m1, input logic [7:0] m2,
                                             input logic [7:0] m3);
    logic [7:0] a0, a1, a2, a3;
    {a0, a1, a2, a3} = c;
    return {gf_mul(a0, m0) ^ gf_mul(a1, m1) ^ gf_mul(a2, m2) ^ gf_mul(a3, m3),
            gf_mul(a0, m3) ^ gf_mul(a1, m0) ^ gf_mul(a2, m1) ^ gf_mul(a3, m2),
            gf_mul(a0, m2) ^ gf_mul(a1, m3) ^ gf_mul(a2, m0) ^ gf_mul(a3, m1),
            gf_mul(a0, m1) ^ gf_mul(a1, m2) ^ gf_mul(a2, m3) ^ gf_mul(a3, m0)};
  endfunction

  function automatic logic [31:0] subst_word(input logic [31:0] w);
    return {sbox_tbl[w[31:24]], sbox_tbl[w[23:16]], sbox_tbl[w[15:8]], sbox_tbl[w[7:0]]};
  endfunction

  function automatic void expand_schedule();
    logic [31:0] w [60];
    logic [255:0] k;
    logic [31:0] t;
    logic [7:0] rc;
    int nk, nr;
    nk = long_key_reg ? 8 : 4;
    nr = long_key_reg ? 14 : 10;
    k = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
    rc = 8'h01;
    for (int i = 0; i < nk; i++) w[i] = k[255-32*i -: 32];
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      t = w[i-1];
      if (i % nk == 0) begin
        t = subst_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = rc[7] ? ({rc[6:0], 1'b0} ^ 8'h1b) : {rc[6:0], 1'b0};
      end else if (nk == 8 && i % nk == 4) begin
        t = subst_word(t);
      end
      w[i] = w[i-nk] ^ t;
    end
    for (int r = 0; r <= nr; r++) sched[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endfunction

  function automatic cipher_word_t predict_cipher(input logic [63:0] hi, input logic [63:0] lo);
    logic [127:0] s, t;
    cipher_word_t res;
    int nr;
    expand_schedule();
    nr = long_key_reg ? 14 : 10;
    s = {hi, lo};
    if (!decrypt_reg) begin
      s = s ^ sched[0];
      for (int r = 1; r <= nr; r++) begin
        for (int c = 0; c < 4; c++)
          for (int row = 0; row < 4; row++)
            t[127-8*(row+4*c) -: 8] = sbox_tbl[s[127-8*(row+4*((c+row)&3)) -: 8]];
        s = t;
        if (r != nr)
          for (int c = 0; c < 4; c++)
            s[127-32*c -: 32] = column_mix(s[127-32*c -: 32], 8'd2, 8'd3, 8'd1, 8'd1);
        s = s ^ sched[r];
      end
    end else begin
      s = s ^ sched[nr];
      for (int r = nr - 1; r >= 0; r--) begin
        for (int c = 0; c < 4; c++)
          for (int row = 0; row < 4; row++)
            t[127-8*(row+4*((c+row)&3)) -: 8] = inv_sbox_tbl[s[127-8*(row+4*c) -: 8]];
        s = t ^ sched[r];
        if (r != 0)
          for (int c = 0; c < 4; c++)
            s[127-32*c -: 32] = column_mix(s[127-32*c -: 32], 8'd14, 8'd11, 8'd13, 8'd9);
      end
    end
    res.high = s[127:64];
    res.low = s[63:0];
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_field();
    case ($urandom_range(9))
      0: return 64'h0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  task automatic send_word(input logic [63:0] hi, input logic [63:0] lo);
    if (idle_en && $urandom_range(3) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_block_high <= hi;
    in_block_low <= lo;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_words.push_back(predict_cipher(hi, lo));
  endtask

  task automatic drain_words();
    @(negedge clk);
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_reg[idx] = data;
      REG_LONG_KEY: long_key_reg = data[0];
      REG_DECRYPT: decrypt_reg = data[0];
      default: ;
    endcase
  endtask

  task automatic set_cipher(input logic [255:0] key, input logic long_key,
                            input logic decrypt);
    drain_words();
    write_reg(REG_KEY0, key[255:192]);
    write_reg(REG_KEY1, key[191:128]);
    write_reg(REG_KEY2, key[127:64]);
    write_reg(REG_KEY3, key[63:0]);
    write_reg(REG_LONG_KEY, {$urandom, $urandom_range(1) == 0 ? 32'h0 : $urandom} & ~64'h1
              | long_key);
    write_reg(REG_DECRYPT, {$urandom, $urandom} & ~64'h1 | decrypt);
  endtask

  task automatic test_reset_state();
    send_word(64'h0, 64'h0);
    send_word('1, '1);
    send_word(64'h0011223344556677, 64'h8899aabbccddeeff);
  endtask

  task automatic test_known_keys();
    logic [255:0] k;
    k = 256'h000102030405060708090a0b0c0d0e0f101112131415161718191a1b1c1d1e1f;
    for (int m = 0; m < 4; m++) begin
      set_cipher(k, m[0], m[1]);
      send_word(64'h0011223344556677, 64'h8899aabbccddeeff);
      send_word(64'h0, '1);
    end
    set_cipher('1, 1'b1, 1'b0);
    send_word('1, 64'h0);
    set_cipher('1, 1'b0, 1'b1);
    send_word(64'h0, 64'h0);
  endtask

  task automatic test_register_edges();
    drain_words();
    write_reg(REG_UNUSED6, '1);
    write_reg(REG_UNUSED7, 64'haaaa_aaaa_aaaa_aaaa);
    send_word(64'h0123456789abcdef, 64'hfedcba9876543210);
    drain_words();
    write_reg(REG_LONG_KEY, 64'hffff_ffff_ffff_fffe);
    write_reg(REG_DECRYPT, 64'h2);
    send_word(64'h0123456789abcdef, 64'hfedcba9876543210);
    drain_words();
    write_reg(REG_KEY0, 64'h8000_0000_0000_0001);
    send_word(64'h0123456789abcdef, 64'hfedcba9876543210);
    drain_words();
    write_reg(REG_KEY2, rand64());
    send_word(64'h0123456789abcdef, 64'hfedcba9876543210);
  endtask

  task automatic test_random_traffic();
    logic [255:0] k;
    for (int p = 0; p < 12; p++) begin
      case (p)
        0: k = '0;
        1: k = '1;
        default: k = {rand64(), rand64(), rand64(), rand64()};
      endcase
      set_cipher(k, p[0], p[1]);
      idle_en = (p < 10);
      for (int n = 0; n < 100; n++) send_word(rand_field(), rand_field());
    end
  endtask

  always @(posedge clk) begin
    cipher_word_t exp_word;
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        $error("out_valid with no word pending");
        fail_count++;
      end else begin
        exp_word = pending_words.pop_front();
        if (out_result_high !== exp_word.high) begin
          $error("result_high expected %h actual %h", exp_word.high, out_result_high);
          fail_count++;
        end
        if (out_result_low !== exp_word.low) begin
          $error("result_low expected %h actual %h", exp_word.low, out_result_low);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("aes_block_cipher test failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_block_high = '0;
    in_block_low = '0;
    cfg_we = 1'b0;
    cfg_index = REG_KEY0;
    cfg_data = '0;
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    long_key_reg = 1'b0;
    decrypt_reg = 1'b0;
    fail_count = 0;
    stall_cycles = 0;
    idle_en = 1'b1;
    build_sbox();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_known_keys();
    test_register_edges();
    test_random_traffic();
    drain_words();
    if (fail_count == 0) begin
      $display("aes_block_cipher test passed");
    end else begin
      $display("aes_block_cipher test failed");
    end
    $finish;
  end
endmodule
